/* rtl/pinhole_projection_depth_color_core_macros.svh */
// assertion macros for the pinhole projection core
// expects clock and reset in the scope where they are used
`ifndef PINHOLE_PROJECTION_DEPTH_COLOR_CORE_MACROS_SVH
`define PINHOLE_PROJECTION_DEPTH_COLOR_CORE_MACROS_SVH

// same-cycle implication
`define PPDC_ASSERT_IMPLY(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ppdc check failed");

// next-cycle implication
`define PPDC_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ppdc check failed");

`endif

/* rtl/ppdc_pkg.sv */
// shared types and constants of the pinhole projection core
// no dependencies
package ppdc_pkg;

   typedef enum logic [1:0] {
      ST_INSIDE  = 2'd0,
      ST_BEHIND  = 2'd1,
      ST_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      REG_FOCAL_X      = 3'd0,
      REG_FOCAL_Y      = 3'd1,
      REG_CENTER_X     = 3'd2,
      REG_CENTER_Y     = 3'd3,
      REG_IMAGE_WIDTH  = 3'd4,
      REG_IMAGE_HEIGHT = 3'd5,
      REG_COLOR_RANGE  = 3'd6
   } reg_index_type;

   localparam int DEPTH_BITS    = 18;
   localparam int COLOR_BITS    = 8;
   localparam int FOCAL_BITS    = 16;
   localparam int SIZE_BITS     = 13;
   localparam int RANGE_BITS    = 16;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
   localparam logic [COLOR_BITS-1:0] COLOR_MAX = 8'd255;

   localparam logic [FOCAL_BITS-1:0] RST_FOCAL_X  = 16'd20617;
   localparam logic [FOCAL_BITS-1:0] RST_FOCAL_Y  = 16'd20700;
   localparam logic [FOCAL_BITS-1:0] RST_CENTER_X = 16'd18876;
   localparam logic [FOCAL_BITS-1:0] RST_CENTER_Y = 16'd12839;
   localparam logic [SIZE_BITS-1:0]  RST_WIDTH    = 13'd2560;
   localparam logic [SIZE_BITS-1:0]  RST_HEIGHT   = 13'd1600;
   localparam logic [RANGE_BITS-1:0] RST_RANGE    = 16'd10000;

endpackage

/* rtl/ppdc_channels.sv */
// request and response channel interfaces of the pinhole projection core
// depends on ppdc_pkg
interface ppdc_req_if #(parameter int COORD_BITS = 18);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   modport source (output valid, point_x, point_y, point_z, input ready);
   modport sink (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppdc_rsp_if #(parameter int PIXEL_BITS = 12);
   import ppdc_pkg::*;
   logic                  valid;
   logic                  ready;
   status_type            status;
   logic [PIXEL_BITS-1:0] pixel_col;
   logic [PIXEL_BITS-1:0] pixel_row;
   logic [DEPTH_BITS-1:0] depth_mm;
   logic [COLOR_BITS-1:0] red_level;
   logic [COLOR_BITS-1:0] blue_level;
   modport source (output valid, status, pixel_col, pixel_row, depth_mm, red_level,
                   blue_level, input ready);
   modport sink (input valid, status, pixel_col, pixel_row, depth_mm, red_level,
                 blue_level, output ready);
endinterface

/* rtl/pinhole_projection_depth_color_core.sv */
// pinhole projection of radar points with euclidean depth and blue-to-red color
// depends on ppdc_pkg, ppdc_channels and the macros header
//
//  channel   dir  handshake        payload
//  req_bus   in   valid / ready    point_x, point_y, point_z
//  rsp_bus   out  valid / ready    status, pixel_col, pixel_row, depth_mm, red/blue
//  apb csr   in   psel / penable   paddr, pwdata, prdata (pready tied high)
//
// one request per clock unless every stage is full and the response is stalled;
// a request passes the radix-2 quotient stages, one square root stage per root
// bit and the eight color quotient stages on its way to the response
// reset is synchronous active high; it clears valid bits and loads csr reset values
// each stage holds its request while the next is occupied and stalled, so
// empty stages fill up while a finished response waits
`include "pinhole_projection_depth_color_core_macros.svh"

module pinhole_projection_depth_color_core #(
   parameter int COORD_BITS = 18,
   parameter int PIXEL_BITS = 12
) (
   input  logic                               clock,
   input  logic                               reset,
   ppdc_req_if.sink                           req_bus,
   ppdc_rsp_if.source                         rsp_bus,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [ppdc_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [ppdc_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [ppdc_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                               pready
);
   import ppdc_pkg::*;

   // widths
   localparam int C   = COORD_BITS;
   localparam int P   = PIXEL_BITS;
   localparam int NW  = C + 19;           // signed projection numerator
   localparam int RW  = NW + P;           // numerator magnitude and shifted divisor
   localparam int DW  = C + 3;            // 16 * forward
   localparam int SN  = 2 * C + 1;        // sum of squares and root work register
   localparam int CDW = DEPTH_BITS + 8;   // 255 * depth
   localparam int BW  = (P > SIZE_BITS) ? P : SIZE_BITS;

   // stage map
   localparam int S_MUL  = 1;
   localparam int S_SUM  = 2;
   localparam int S_OVF  = 3;
   localparam int S_DIV0 = 4;
   localparam int S_BND  = S_DIV0 + P;
   localparam int S_SQ0  = S_BND + 1;
   localparam int S_SAT  = S_SQ0 + C;
   localparam int S_COL0 = S_SAT + 1;
   localparam int S_FMT  = S_COL0 + COLOR_BITS;
   localparam int NST    = S_FMT + 1;

   typedef struct packed {
      status_type             status;
      logic signed [C-1:0]    px;
      logic signed [C-1:0]    py;
      logic signed [C-1:0]    pz;
      logic signed [C+16:0]   xf;
      logic signed [C+16:0]   zf;
      logic signed [C+16:0]   cx;
      logic signed [C+16:0]   cy;
      logic [2*C-1:0]         sqx;
      logic [2*C-1:0]         sqy;
      logic [2*C-1:0]         sqz;
      logic                   neg_x;
      logic                   neg_y;
      logic [RW-1:0]          mag_x;
      logic [RW-1:0]          mag_y;
      logic [DW-1:0]          den;
      logic [P-1:0]           q_x;
      logic [P-1:0]           q_y;
      logic [SN-1:0]          sq_n;
      logic [SN-1:0]          sq_res;
      logic [DEPTH_BITS-1:0]  depth;
      logic                   csat;
      logic [CDW-1:0]         cdiv;
      logic [COLOR_BITS-1:0]  cq;
      logic [COLOR_BITS-1:0]  red;
      logic [COLOR_BITS-1:0]  blue;
   } item_type;

   // csr file
   logic [FOCAL_BITS-1:0] focal_x_ff, focal_y_ff, center_x_ff, center_y_ff;
   logic [SIZE_BITS-1:0]  image_width_ff, image_height_ff;
   logic [RANGE_BITS-1:0] color_range_ff;
   logic                  csr_write;
   reg_index_type         csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_BITS-1:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_x_ff      <= RST_FOCAL_X;
         focal_y_ff      <= RST_FOCAL_Y;
         center_x_ff     <= RST_CENTER_X;
         center_y_ff     <= RST_CENTER_Y;
         image_width_ff  <= RST_WIDTH;
         image_height_ff <= RST_HEIGHT;
         color_range_ff  <= RST_RANGE;
      end else if (csr_write) begin
         case (csr_index)
            REG_FOCAL_X:      focal_x_ff      <= pwdata[FOCAL_BITS-1:0];
            REG_FOCAL_Y:      focal_y_ff      <= pwdata[FOCAL_BITS-1:0];
            REG_CENTER_X:     center_x_ff     <= pwdata[FOCAL_BITS-1:0];
            REG_CENTER_Y:     center_y_ff     <= pwdata[FOCAL_BITS-1:0];
            REG_IMAGE_WIDTH:  image_width_ff  <= pwdata[SIZE_BITS-1:0];
            REG_IMAGE_HEIGHT: image_height_ff <= pwdata[SIZE_BITS-1:0];
            REG_COLOR_RANGE:  color_range_ff  <= pwdata[RANGE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      case (csr_index)
         REG_FOCAL_X:      prdata = CSR_DATA_BITS'(focal_x_ff);
         REG_FOCAL_Y:      prdata = CSR_DATA_BITS'(focal_y_ff);
         REG_CENTER_X:     prdata = CSR_DATA_BITS'(center_x_ff);
         REG_CENTER_Y:     prdata = CSR_DATA_BITS'(center_y_ff);
         REG_IMAGE_WIDTH:  prdata = CSR_DATA_BITS'(image_width_ff);
         REG_IMAGE_HEIGHT: prdata = CSR_DATA_BITS'(image_height_ff);
         REG_COLOR_RANGE:  prdata = CSR_DATA_BITS'(color_range_ff);
         default:          prdata = '0;
      endcase
   end

   // pipeline registers and per-stage load enables
   item_type        pipe_in [NST];
   item_type        pipe_ff [NST];
   logic [NST-1:0]  vld_ff;
   logic [NST-1:0]  load;

   // a stage loads when it is empty or its content moves on
   always_comb begin
      load[NST-1] = !vld_ff[NST-1] || rsp_bus.ready;
      for (int i = NST - 2; i >= 0; i--) begin
         load[i] = !vld_ff[i] || load[i+1];
      end
   end

   assign req_bus.ready = load[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NST; i++) begin
            if (load[i]) begin
               vld_ff[i] <= (i == 0) ? req_bus.valid : vld_ff[(i == 0) ? 0 : i - 1];
            end
         end
      end
   end

   // input capture
   always_comb begin
      pipe_in[0]    = '0;
      pipe_in[0].px = req_bus.point_x;
      pipe_in[0].py = req_bus.point_y;
      pipe_in[0].pz = req_bus.point_z;
   end

   for (genvar i = 0; i < NST; i++) begin : g_stage
      always_ff @(posedge clock) begin
         if (load[i]) begin
            pipe_ff[i] <= pipe_in[i];
         end
      end

      if (i == S_MUL) begin : g_mul
         // projection products and squares of the three axes
         always_comb begin
            pipe_in[i]     = pipe_ff[i-1];
            pipe_in[i].xf  = pipe_ff[i-1].px * $signed({1'b0, focal_x_ff});
            pipe_in[i].zf  = pipe_ff[i-1].pz * $signed({1'b0, focal_y_ff});
            pipe_in[i].cx  = $signed({1'b0, center_x_ff}) * pipe_ff[i-1].py;
            pipe_in[i].cy  = $signed({1'b0, center_y_ff}) * pipe_ff[i-1].py;
            pipe_in[i].sqx = pipe_ff[i-1].px * pipe_ff[i-1].px;
            pipe_in[i].sqy = pipe_ff[i-1].py * pipe_ff[i-1].py;
            pipe_in[i].sqz = pipe_ff[i-1].pz * pipe_ff[i-1].pz;
         end
      end else if (i == S_SUM) begin : g_sum
         // numerators, sign and magnitude; down axis is minus z
         always_comb begin
            logic signed [NW-1:0] num_x;
            logic signed [NW-1:0] num_y;
            num_x = NW'(pipe_ff[i-1].xf) + NW'(pipe_ff[i-1].cx);
            num_y = NW'(pipe_ff[i-1].cy) - NW'(pipe_ff[i-1].zf);
            pipe_in[i]        = pipe_ff[i-1];
            pipe_in[i].neg_x  = num_x[NW-1];
            pipe_in[i].neg_y  = num_y[NW-1];
            pipe_in[i].mag_x  = RW'($unsigned(num_x[NW-1] ? -num_x : num_x));
            pipe_in[i].mag_y  = RW'($unsigned(num_y[NW-1] ? -num_y : num_y));
            pipe_in[i].den    = {pipe_ff[i-1].py[C-2:0], 4'b0000};
            pipe_in[i].status = (pipe_ff[i-1].py[C-1] || pipe_ff[i-1].py == '0) ?
                                ST_BEHIND : ST_INSIDE;
            pipe_in[i].sq_n   = SN'(pipe_ff[i-1].sqx) + SN'(pipe_ff[i-1].sqy) +
                                SN'(pipe_ff[i-1].sqz);
            pipe_in[i].sq_res = '0;
            pipe_in[i].q_x    = '0;
            pipe_in[i].q_y    = '0;
         end
      end else if (i == S_OVF) begin : g_ovf
         // quotient would not fit the pixel field
         always_comb begin
            logic [RW-1:0] lim;
            lim        = RW'(pipe_ff[i-1].den) << P;
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].status == ST_INSIDE &&
                (pipe_ff[i-1].mag_x >= lim || pipe_ff[i-1].mag_y >= lim)) begin
               pipe_in[i].status = ST_OUTSIDE;
            end
         end
      end else if (i >= S_DIV0 && i < S_BND) begin : g_div
         // one restoring quotient bit per stage, both axes
         localparam int K = P - 1 - (i - S_DIV0);
         always_comb begin
            logic [RW-1:0] t;
            t          = RW'(pipe_ff[i-1].den) << K;
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].mag_x >= t) begin
               pipe_in[i].mag_x  = pipe_ff[i-1].mag_x - t;
               pipe_in[i].q_x[K] = 1'b1;
            end
            if (pipe_ff[i-1].mag_y >= t) begin
               pipe_in[i].mag_y  = pipe_ff[i-1].mag_y - t;
               pipe_in[i].q_y[K] = 1'b1;
            end
         end
      end else if (i == S_BND) begin : g_bnd
         // negative pixel or beyond the frame
         always_comb begin
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].status == ST_INSIDE &&
                ((pipe_ff[i-1].neg_x && pipe_ff[i-1].q_x != '0) ||
                 (pipe_ff[i-1].neg_y && pipe_ff[i-1].q_y != '0) ||
                 BW'(pipe_ff[i-1].q_x) >= BW'(image_width_ff) ||
                 BW'(pipe_ff[i-1].q_y) >= BW'(image_height_ff))) begin
               pipe_in[i].status = ST_OUTSIDE;
            end
         end
      end else if (i >= S_SQ0 && i < S_SAT) begin : g_sqrt
         // digit-by-digit square root, one root bit per stage
         localparam int SH = 2 * (C - 1 - (i - S_SQ0));
         always_comb begin
            logic [SN-1:0] bitv;
            logic [SN-1:0] trial;
            bitv       = SN'(1) << SH;
            trial      = pipe_ff[i-1].sq_res + bitv;
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].sq_n >= trial) begin
               pipe_in[i].sq_n   = pipe_ff[i-1].sq_n - trial;
               pipe_in[i].sq_res = (pipe_ff[i-1].sq_res >> 1) + bitv;
            end else begin
               pipe_in[i].sq_res = pipe_ff[i-1].sq_res >> 1;
            end
         end
      end else if (i == S_SAT) begin : g_sat
         // clamp depth, full-range test, 255 * depth
         always_comb begin
            logic [DEPTH_BITS-1:0] d;
            d = (pipe_ff[i-1].sq_res > SN'(DEPTH_MAX)) ? DEPTH_MAX :
                pipe_ff[i-1].sq_res[DEPTH_BITS-1:0];
            pipe_in[i]       = pipe_ff[i-1];
            pipe_in[i].depth = d;
            pipe_in[i].csat  = d >= DEPTH_BITS'(color_range_ff);
            pipe_in[i].cdiv  = {d, 8'b0} - CDW'(d);
            pipe_in[i].cq    = '0;
         end
      end else if (i >= S_COL0 && i < S_FMT) begin : g_col
         // color quotient, one bit per stage
         localparam int K = COLOR_BITS - 1 - (i - S_COL0);
         always_comb begin
            logic [CDW-1:0] t;
            t          = CDW'(color_range_ff) << K;
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].cdiv >= t) begin
               pipe_in[i].cdiv  = pipe_ff[i-1].cdiv - t;
               pipe_in[i].cq[K] = 1'b1;
            end
         end
      end else if (i == S_FMT) begin : g_fmt
         // blue is the floor of the complement: one less when the division is inexact
         always_comb begin
            pipe_in[i] = pipe_ff[i-1];
            if (pipe_ff[i-1].status != ST_INSIDE) begin
               pipe_in[i].q_x   = '0;
               pipe_in[i].q_y   = '0;
               pipe_in[i].depth = '0;
               pipe_in[i].red   = '0;
               pipe_in[i].blue  = '0;
            end else if (pipe_ff[i-1].csat) begin
               pipe_in[i].red  = COLOR_MAX;
               pipe_in[i].blue = '0;
            end else begin
               pipe_in[i].red  = pipe_ff[i-1].cq;
               pipe_in[i].blue = COLOR_MAX - pipe_ff[i-1].cq -
                                 COLOR_BITS'(pipe_ff[i-1].cdiv != '0);
            end
         end
      end
   end

   // response
   assign rsp_bus.valid      = vld_ff[NST-1];
   assign rsp_bus.status     = pipe_ff[NST-1].status;
   assign rsp_bus.pixel_col  = pipe_ff[NST-1].q_x;
   assign rsp_bus.pixel_row  = pipe_ff[NST-1].q_y;
   assign rsp_bus.depth_mm   = pipe_ff[NST-1].depth;
   assign rsp_bus.red_level  = pipe_ff[NST-1].red;
   assign rsp_bus.blue_level = pipe_ff[NST-1].blue;

   // checks
   logic       rsp_reject;
   logic       rsp_inside;
   logic       rsp_zero;
   logic [8:0] color_sum;

   assign rsp_reject = rsp_bus.valid && rsp_bus.status != ST_INSIDE;
   assign rsp_inside = rsp_bus.valid && rsp_bus.status == ST_INSIDE;
   assign rsp_zero   = rsp_bus.pixel_col == '0 && rsp_bus.pixel_row == '0 &&
                       rsp_bus.depth_mm == '0 && rsp_bus.red_level == '0 &&
                       rsp_bus.blue_level == '0;
   assign color_sum  = 9'(rsp_bus.red_level) + 9'(rsp_bus.blue_level);

   `PPDC_ASSERT_IMPLY(a_reject_zeroed, rsp_reject, rsp_zero)
   `PPDC_ASSERT_IMPLY(a_color_sum, rsp_inside, color_sum == 9'd255 || color_sum == 9'd254)
   `PPDC_ASSERT_IMPLY(a_full_blocks, (&vld_ff) && !rsp_bus.ready, !req_bus.ready)
   `PPDC_ASSERT_NEXT(a_accept_enters, req_bus.valid && req_bus.ready, vld_ff[0])

endmodule

/* test/pinhole_projection_depth_color_core_checker.sv */
// checker for the pinhole projection core: tracks csr writes, predicts each response
// depends on ppdc_pkg and the channel interfaces in ppdc_channels
`timescale 1ns / 1ps

module pinhole_projection_depth_color_core_checker
   import ppdc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   ppdc_req_if                      req_bus,
   ppdc_rsp_if                      rsp_bus,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic                     pready,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output int                       fail_count,
   output int                       outstanding
);

   typedef struct packed {
      status_type            status;
      logic [11:0]           col;
      logic [11:0]           row;
      logic [DEPTH_BITS-1:0] depth;
      logic [COLOR_BITS-1:0] red;
      logic [COLOR_BITS-1:0] blue;
   } pixel_type;

   logic [FOCAL_BITS-1:0] focal_x, focal_y, center_x, center_y;
   logic [SIZE_BITS-1:0]  width, height;
   logic [RANGE_BITS-1:0] color_range;

   pixel_type expected_pixels[$];

   assign outstanding = expected_pixels.size();

   function automatic longint floor_sqrt(longint n);
      longint root, trial;
      root = 0;
      for (int b = 20; b >= 0; b--) begin
         trial = root | (longint'(1) << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   function automatic pixel_type project_point(logic signed [17:0] px,
                                               logic signed [17:0] py,
                                               logic signed [17:0] pz);
      pixel_type p;
      longint right, fwd, down, col, row, depth;
      p = '0;
      p.status = ST_INSIDE;
      right = px;
      fwd   = py;
      down  = -longint'(pz);
      if (fwd <= 0) begin
         p.status = ST_BEHIND;
         return p;
      end
      col = (right * longint'(focal_x) + longint'(center_x) * fwd) / (16 * fwd);
      row = (down * longint'(focal_y) + longint'(center_y) * fwd) / (16 * fwd);
      if (col < 0 || row < 0 || col >= longint'(width) || row >= longint'(height) ||
          col >= 4096 || row >= 4096) begin
         p.status = ST_OUTSIDE;
         return p;
      end
      depth = floor_sqrt(right * right + down * down + fwd * fwd);
      if (depth > longint'(DEPTH_MAX)) depth = longint'(DEPTH_MAX);
      p.col   = col[11:0];
      p.row   = row[11:0];
      p.depth = depth[DEPTH_BITS-1:0];
      if (depth >= longint'(color_range)) begin
         p.red  = COLOR_MAX;
         p.blue = '0;
      end else begin
         p.red  = 8'((255 * depth) / longint'(color_range));
         p.blue = 8'((255 * (longint'(color_range) - depth)) / longint'(color_range));
      end
      return p;
   endfunction

   always @(posedge clock) begin
      pixel_type exp_p, got;
      reg_index_type idx;
      if (reset) begin
         focal_x     <= RST_FOCAL_X;
         focal_y     <= RST_FOCAL_Y;
         center_x    <= RST_CENTER_X;
         center_y    <= RST_CENTER_Y;
         width       <= RST_WIDTH;
         height      <= RST_HEIGHT;
         color_range <= RST_RANGE;
         fail_count  <= 0;
         expected_pixels.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            idx = reg_index_type'(paddr[4:2]);
            case (idx)
               REG_FOCAL_X:      focal_x     <= pwdata[FOCAL_BITS-1:0];
               REG_FOCAL_Y:      focal_y     <= pwdata[FOCAL_BITS-1:0];
               REG_CENTER_X:     center_x    <= pwdata[FOCAL_BITS-1:0];
               REG_CENTER_Y:     center_y    <= pwdata[FOCAL_BITS-1:0];
               REG_IMAGE_WIDTH:  width       <= pwdata[SIZE_BITS-1:0];
               REG_IMAGE_HEIGHT: height      <= pwdata[SIZE_BITS-1:0];
               REG_COLOR_RANGE:  color_range <= pwdata[RANGE_BITS-1:0];
               default: ;
            endcase
         end
         if (req_bus.valid && req_bus.ready)
            expected_pixels.push_back(project_point(req_bus.point_x, req_bus.point_y,
                                                    req_bus.point_z));
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = {rsp_bus.status, rsp_bus.pixel_col, rsp_bus.pixel_row, rsp_bus.depth_mm,
                   rsp_bus.red_level, rsp_bus.blue_level};
            if (expected_pixels.size() == 0) begin
               if (fail_count < 10)
                  $display("unexpected response status %0d", got.status);
               fail_count <= fail_count + 1;
            end else begin
               exp_p = expected_pixels.pop_front();
               if (got !== exp_p) begin
                  if (fail_count < 10)
                     $display({"mismatch: exp st %0d col %0d row %0d d %0d r %0d b %0d",
                               " / got st %0d col %0d row %0d d %0d r %0d b %0d"},
                              exp_p.status, exp_p.col, exp_p.row, exp_p.depth, exp_p.red,
                              exp_p.blue, got.status, got.col, got.row, got.depth,
                              got.red, got.blue);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* test/pinhole_projection_depth_color_core_tb.sv */
// testbench top for the pinhole projection core: drives points and csr phases
// depends on ppdc_pkg, ppdc_channels, the core and its checker
`timescale 1ns / 1ps

module pinhole_projection_depth_color_core_tb;
   import ppdc_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0] paddr = '0;
   logic [CSR_DATA_BITS-1:0] pwdata = '0;
   logic [CSR_DATA_BITS-1:0] prdata;
   logic pready;
   int   fail_count, outstanding;
   logic steady = 1'b0;      // no idling on either side
   logic req_taken = 1'b0;   // request accepted at the last rising edge
   int   ready_hold = 0;

   ppdc_req_if #(.COORD_BITS(18)) req_bus ();
   ppdc_rsp_if #(.PIXEL_BITS(12)) rsp_bus ();

   pinhole_projection_depth_color_core u_top (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   pinhole_projection_depth_color_core_checker u_checker (
      .clock(clock), .reset(reset), .req_bus(req_bus), .rsp_bus(rsp_bus),
      .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
      .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count), .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   // registered view of the request handshake, read one step after the edge
   always @(posedge clock) req_taken <= req_bus.valid && req_bus.ready;

   // response side stalls in bursts at random unless steady
   always @(negedge clock) begin
      int hold;
      hold = ready_hold;
      if (steady) hold = 0;
      else if (hold == 0 && $urandom_range(0, 9) == 0) hold = $urandom_range(1, 15);
      if (hold > 0) begin
         rsp_bus.ready <= 1'b0;
         ready_hold <= hold - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         ready_hold <= 0;
      end
   end

   // apb write, setup phase then access phase
   task automatic csr_write(reg_index_type idx, logic [31:0] value);
      @(negedge clock);
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
      paddr <= {idx, 2'b00}; pwdata <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(negedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
   endtask

   // one request; an optional idle burst goes in front unless steady
   task automatic send_point(int px, int py, int pz);
      if (!steady && $urandom_range(0, 7) == 0) begin
         @(negedge clock);
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(0, 14)) @(negedge clock);
      end
      @(negedge clock);
      req_bus.valid   <= 1'b1;
      req_bus.point_x <= 18'(px);
      req_bus.point_y <= 18'(py);
      req_bus.point_z <= 18'(pz);
      do begin
         @(posedge clock);
         #1;
      end while (!req_taken);
   endtask

   // mostly points in front of the camera spread around the frame, some raw noise
   task automatic send_random_point();
      int fwd, right, down;
      if ($urandom_range(0, 3) == 0) begin
         send_point($urandom, $urandom, $urandom);
      end else begin
         fwd   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 200)
                                              : $urandom_range(1, 131071);
         right = int'($urandom_range(0, 2 * fwd)) - fwd;
         down  = int'($urandom_range(0, 2 * fwd)) - fwd;
         if (right > 131071) right = 131071;
         if (down > 131071) down = 131071;
         send_point(right, fwd, -down);
      end
   endtask

   // settle between phases: drain, then cover the pipeline depth
   task automatic drain();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic load_config(int fx, int fy, int cx, int cy, int w, int h, int r);
      csr_write(REG_FOCAL_X, fx);
      csr_write(REG_FOCAL_Y, fy);
      csr_write(REG_CENTER_X, cx);
      csr_write(REG_CENTER_Y, cy);
      csr_write(REG_IMAGE_WIDTH, w);
      csr_write(REG_IMAGE_HEIGHT, h);
      csr_write(REG_COLOR_RANGE, r);
   endtask

   initial begin
      req_bus.valid   = 1'b0;
      req_bus.point_x = '0;
      req_bus.point_y = '0;
      req_bus.point_z = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed points at reset intrinsics
      send_point(0, 0, 0);                   // forward zero is behind
      send_point(5, -1, 5);                  // negative forward
      send_point(0, -131072, 0);
      send_point(0, 131071, 0);              // far on axis
      send_point(131071, 131071, 131071);
      send_point(-131072, 131071, -131072);
      send_point(0, 1000, 0);                // optical center
      send_point(0, 1, 0);                   // nearest forward
      send_point(1, 1, 0);                   // one unit right, still inside the frame
      send_point(-1, 1, 0);                  // negative column
      send_point(0, 1, 1);                   // negative row
      send_point(0, 10000, 0);               // depth equals color range
      send_point(0, 9999, 0);
      send_point(0, 20000, 0);               // beyond color range
      send_point(900, 1000, 600);
      send_point(-900, 1000, -600);
      send_point(131071, 1, 0);
      send_point(0, 1, -131072);
      repeat (200) send_random_point();
      drain();

      // every point in front maps to pixel zero in a one-pixel frame
      load_config(0, 0, 0, 0, 1, 1, 1);
      repeat (200) send_random_point();
      drain();
      // largest intrinsics and a frame the size of the pixel field
      load_config(65535, 65535, 65535, 65535, 4096, 4096, 65535);
      repeat (200) send_random_point();
      drain();
      // empty frame, zero color range
      load_config(20617, 20700, 18876, 12839, 0, 0, 0);
      repeat (280) send_random_point();
      drain();
      // frame wider than the pixel field
      load_config(20617, 20700, 18876, 12839, 8191, 8191, 0);
      repeat (200) send_random_point();
      drain();
      load_config(16, 16, 32000, 32000, 4096, 4096, 500);
      repeat (200) send_random_point();
      drain();
      load_config($urandom_range(8000, 40000), $urandom_range(8000, 40000),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(1, 4096), $urandom_range(1, 4096),
                  $urandom_range(1, 65535));
      repeat (200) send_random_point();
      drain();

      // last stretch at reset values with no idling
      load_config(20617, 20700, 18876, 12839, 2560, 1600, 10000);
      steady <= 1'b1;
      repeat (200) send_random_point();
      @(negedge clock);
      req_bus.valid <= 1'b0;

      while (outstanding != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (fail_count == 0)
         $display("pinhole_projection_depth_color_core_tb: PASS");
      else
         $display("pinhole_projection_depth_color_core_tb: FAIL");
      $finish;
   end

   // run limit
   initial begin
      #20ms;
      $display("pinhole_projection_depth_color_core_tb: FAIL");
      $finish;
   end

endmodule
